>>> src/replay_window_filter_defines.svh
// assertion macros shared by the replay window filter modules
// each macro expects clk and rst_n in the module that uses it
`ifndef REPLAY_WINDOW_FILTER_DEFINES_SVH
`define REPLAY_WINDOW_FILTER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RWF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RWF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rwf_pkg.sv
// shared types and constants for the replay window filter
// no dependencies
package rwf_pkg;

    localparam int SID_W = 32;
    localparam int SEQ_W = 32;

    localparam logic [SEQ_W-1:0] HALF_SPACE = 32'h8000_0000;

    typedef enum logic [2:0] {
        VERDICT_INVALID      = 3'd0,
        VERDICT_NEWER        = 3'd1,
        VERDICT_DUPLICATE    = 3'd2,
        VERDICT_AMBIGUOUS    = 3'd3,
        VERDICT_STALE        = 3'd4,
        VERDICT_OUT_OF_ORDER = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [SID_W-1:0] session_tag;
        logic [SEQ_W-1:0] sequence_req;
    } item_t;

endpackage

>>> src/rwf_window.sv
// window state (session, newest sequence, bitmap) and the per-packet judgement
// depends on rwf_pkg and replay_window_filter_defines.svh
`include "replay_window_filter_defines.svh"

module rwf_window #(
    parameter int WINDOW_BITS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  rwf_pkg::item_t   item,
    output rwf_pkg::verdict_t verdict
);

    localparam int IdxW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;

    logic [WINDOW_BITS-1:0]      bitmap_reg;
    logic [WINDOW_BITS-1:0]      bitmap_next;
    logic [rwf_pkg::SID_W-1:0]   session_reg;
    logic [rwf_pkg::SID_W-1:0]   session_next;
    logic [rwf_pkg::SEQ_W-1:0]   newest_reg;
    logic [rwf_pkg::SEQ_W-1:0]   newest_next;
    logic                        valid_reg;
    logic                        valid_next;

    logic [rwf_pkg::SEQ_W-1:0]   fwd_diff;
    logic [rwf_pkg::SEQ_W-1:0]   back_diff;
    logic                        fwd_in_window;
    logic                        back_in_window;
    logic [IdxW-1:0]             fwd_idx;
    logic [IdxW-1:0]             back_idx;
    logic [WINDOW_BITS-1:0]      back_bit;

    always_comb
    begin
        fwd_diff       = item.sequence_req - newest_reg;
        back_diff      = newest_reg - item.sequence_req;
        fwd_in_window  = fwd_diff < rwf_pkg::SEQ_W'(WINDOW_BITS);
        back_in_window = back_diff < rwf_pkg::SEQ_W'(WINDOW_BITS);
        fwd_idx        = fwd_diff[IdxW-1:0];
        back_idx       = back_diff[IdxW-1:0];
        back_bit       = WINDOW_BITS'(1) << back_idx;

        bitmap_next  = bitmap_reg;
        session_next = session_reg;
        newest_next  = newest_reg;
        valid_next   = valid_reg;
        verdict      = rwf_pkg::VERDICT_INVALID;

        if (item.session_tag == '0 || item.sequence_req == '0)
        begin
            verdict = rwf_pkg::VERDICT_INVALID;
        end
        else if (!valid_reg || session_reg != item.session_tag)
        begin
            // first packet or new session restarts the window
            bitmap_next  = WINDOW_BITS'(1);
            session_next = item.session_tag;
            newest_next  = item.sequence_req;
            valid_next   = 1'b1;
            verdict      = rwf_pkg::VERDICT_NEWER;
        end
        else if (item.sequence_req == newest_reg)
        begin
            verdict = rwf_pkg::VERDICT_DUPLICATE;
        end
        else if (fwd_diff == rwf_pkg::HALF_SPACE)
        begin
            verdict = rwf_pkg::VERDICT_AMBIGUOUS;
        end
        else if (!fwd_diff[rwf_pkg::SEQ_W-1])
        begin
            // newer: slide the bitmap, drop bits past the window
            if (fwd_in_window)
            begin
                bitmap_next = (bitmap_reg << fwd_idx) | WINDOW_BITS'(1);
            end
            else
            begin
                bitmap_next = WINDOW_BITS'(1);
            end
            newest_next = item.sequence_req;
            verdict     = rwf_pkg::VERDICT_NEWER;
        end
        else if (!back_in_window)
        begin
            verdict = rwf_pkg::VERDICT_STALE;
        end
        else if ((bitmap_reg & back_bit) != '0)
        begin
            verdict = rwf_pkg::VERDICT_DUPLICATE;
        end
        else
        begin
            bitmap_next = bitmap_reg | back_bit;
            verdict     = rwf_pkg::VERDICT_OUT_OF_ORDER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg  <= '0;
            session_reg <= '0;
            newest_reg  <= '0;
            valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            bitmap_reg  <= bitmap_next;
            session_reg <= session_next;
            newest_reg  <= newest_next;
            valid_reg   <= valid_next;
        end
    end

    `RWF_ASSERT_NOW(a_newest_bit_set, valid_reg, bitmap_reg[0],
        "window valid but bit for newest sequence is clear")
    `RWF_ASSERT_NEXT(a_valid_after_good,
        en && item.session_tag != '0 && item.sequence_req != '0, valid_reg,
        "window not valid after a well-formed packet")
    `RWF_ASSERT_NEXT(a_hold_when_idle, !en,
        $stable(bitmap_reg) && $stable(newest_reg) && $stable(session_reg),
        "window state changed without a packet")

endmodule

>>> src/replay_window_filter.sv
// top level of the replay window filter: input register, judge, result register
// depends on rwf_pkg, rwf_window and replay_window_filter_defines.svh
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  in       | in_valid / in_stall | session_tag[31:0], sequence_req[31:0]
//  out      | out_valid/out_stall | verdict[2:0]
//
// one transaction per cycle sustained while out_stall is low; each
// transaction is held in the input register, judged by the combinational
// subtract, compare and bitmap shift, and its verdict and out_valid are set
// in the result register
// reset clears the window (no session, empty bitmap) and both valid flags
// out_stall holds the result register; an empty input register still takes
// one more transaction, then in_stall rises until the result is taken
`include "replay_window_filter_defines.svh"

module replay_window_filter #(
    parameter int WINDOW_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] session_tag,
    input  logic [31:0] sequence_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  verdict
);

    logic               in_valid_reg;
    logic               in_valid_next;
    rwf_pkg::item_t     item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    rwf_pkg::verdict_t  verdict_reg;
    rwf_pkg::verdict_t  judge_verdict;
    logic               advance;
    logic               fire;
    logic               accept_in;

    // result slot is free or being emptied this cycle
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign accept_in = in_valid && !in_stall;

    assign in_valid_next  = accept_in || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    rwf_window #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (fire),
        .item    (item_reg),
        .verdict (judge_verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            item_reg.session_tag  <= session_tag;
            item_reg.sequence_req <= sequence_req;
        end
        if (fire)
        begin
            verdict_reg <= judge_verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    `RWF_ASSERT_NEXT(a_in_held, in_valid_reg && !advance, in_valid_reg,
        "pending transaction dropped from input register")
    `RWF_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg,
        "judged transaction did not reach result register")
    `RWF_ASSERT_NEXT(a_zero_is_invalid,
        fire && (item_reg.session_tag == '0 || item_reg.sequence_req == '0),
        verdict_reg == rwf_pkg::VERDICT_INVALID,
        "zero session or sequence not reported invalid")

endmodule
